// ===== design/sft_pkg.sv =====
// ----------------------------------------------------------------------------
// sft_pkg: shared types, constants and tables of the field tokenizer
// Holds the result and bundle types passed between the tokenizer parts,
// the byte codes it recognizes and the escape designator tables.
// ----------------------------------------------------------------------------
package sft_pkg;

	// Byte codes that steer the tokenizer.
	localparam logic [7:0] BYTE_ESC  = 8'h1B;
	localparam logic [7:0] BYTE_SEMI = 8'h3B;
	localparam logic [7:0] BYTE_N    = 8'h4E;

	// Designator ranges after ESC N.
	localparam logic [7:0] LOW_FIRST    = 8'h21;
	localparam logic [7:0] LOW_LAST     = 8'h3F;
	localparam logic [7:0] ACCENT_FIRST = 8'h40;
	localparam logic [7:0] HIGH_FIRST   = 8'h50;
	localparam logic [7:0] HIGH_LAST    = 8'h7E;

	// Bound on results one input byte can cause, and the bundle queue depth.
	localparam int MAX_RES    = 4;
	localparam int QUEUE_DEPTH = 4;
	localparam int RES_IDX_W  = $clog2(MAX_RES);
	localparam int RES_CNT_W  = $clog2(MAX_RES + 1);
	localparam int Q_PTR_W    = $clog2(QUEUE_DEPTH);
	localparam int Q_CNT_W    = $clog2(QUEUE_DEPTH + 1);

	// One result item.
	typedef struct packed {
		logic [7:0] data;
		logic       byte_valid;
		logic       field_end;
		logic       line_done;
	} res_t;

	// All results caused by one input byte, oldest in item[0].
	typedef struct packed {
		res_t [MAX_RES-1:0]   item;
		logic [RES_CNT_W-1:0] cnt;
	} bundle_t;

	// Code points for designators 0x21-0x3F.
	localparam logic [8:0] LOW_MAP [0:30] = '{
		9'h0A1, 9'h0A2, 9'h0A3, 9'h024, 9'h0A5, 9'h023, 9'h0A7, 9'h0A4,
		9'h027, 9'h022, 9'h0AB, 9'h02C, 9'h02D, 9'h02E, 9'h02F, 9'h0B0,
		9'h0B1, 9'h0B2, 9'h0B3, 9'h034, 9'h0B5, 9'h0B6, 9'h0B7, 9'h038,
		9'h027, 9'h022, 9'h0BB, 9'h0BC, 9'h0BD, 9'h0BE, 9'h0BF
	};

	// Code points for designators 0x50-0x7E.
	localparam logic [8:0] HIGH_MAP [0:46] = '{
		9'h0AF, 9'h0AC, 9'h0AE, 9'h0A9, 9'h054, 9'h055, 9'h056, 9'h057,
		9'h058, 9'h059, 9'h05A, 9'h05B, 9'h05C, 9'h05D, 9'h05E, 9'h05F,
		9'h060, 9'h0C6, 9'h0D0, 9'h0AA, 9'h064, 9'h065, 9'h066, 9'h067,
		9'h068, 9'h0D8, 9'h152, 9'h0B0, 9'h0DE, 9'h06D, 9'h06E, 9'h06F,
		9'h070, 9'h0E6, 9'h072, 9'h0F0, 9'h074, 9'h075, 9'h076, 9'h077,
		9'h078, 9'h0F8, 9'h153, 9'h0DF, 9'h0DE, 9'h07D, 9'h07E
	};

	// Accent designator low nibble to {known, offset from U+0300}.
	function automatic logic [6:0] accent_lookup(input logic [3:0] idx);
		logic [6:0] r;
		case (idx)
			4'h1:    r = {1'b1, 6'h00};
			4'h2:    r = {1'b1, 6'h01};
			4'h3:    r = {1'b1, 6'h02};
			4'h4:    r = {1'b1, 6'h03};
			4'h8:    r = {1'b1, 6'h08};
			4'hA:    r = {1'b1, 6'h0A};
			4'hB:    r = {1'b1, 6'h27};
			default: r = 7'h00;
		endcase
		return r;
	endfunction

endpackage

// ===== design/sft_front.sv =====
// ----------------------------------------------------------------------------
// sft_front: byte classifier of the field tokenizer
// Accepts one byte a cycle unless the queue is full, tracks semicolon and
// escape state and builds the bundle of results that byte causes.
// ----------------------------------------------------------------------------
module sft_front (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  logic [7:0]       in_byte,
	input  logic             line_end,
	input  logic             q_full,
	output logic             push,
	output sft_pkg::bundle_t push_bundle
);

	// Escape phase codes.
	localparam logic [1:0] PH_PLAIN  = 2'd0;
	localparam logic [1:0] PH_ESC    = 2'd1;
	localparam logic [1:0] PH_DESIG  = 2'd2;
	localparam logic [1:0] PH_ACCENT = 2'd3;

	logic [1:0] phase_q, phase_d;
	logic       semi_q, semi_d;
	logic [5:0] accent_q, accent_d;
	logic       known_q, known_d;
	logic       take;

	sft_pkg::res_t [sft_pkg::MAX_RES-1:0] res;
	logic [sft_pkg::RES_CNT_W-1:0] n;

	assign in_stall = q_full;
	assign take     = in_valid && !q_full;
	assign push     = take && (n != '0);

	// Results and next state for the offered byte.
	always_comb begin
		logic       consumed;
		logic [8:0] cp;
		logic [6:0] acc;
		logic [7:0] off;
		res      = '0;
		n        = '0;
		consumed = 1'b0;
		cp       = '0;
		acc      = '0;
		off      = '0;
		phase_d  = phase_q;
		semi_d   = semi_q;
		accent_d = accent_q;
		known_d  = known_q;

		// A pending semicolon is resolved by this byte.
		if (semi_q) begin
			semi_d = 1'b0;
			if (in_byte == sft_pkg::BYTE_SEMI) begin
				res[n[sft_pkg::RES_IDX_W-1:0]] = '{sft_pkg::BYTE_SEMI, 1'b1, 1'b0, 1'b0};
				n = n + 1'b1;
				consumed = 1'b1;
			end else begin
				res[n[sft_pkg::RES_IDX_W-1:0]] = '{8'h00, 1'b0, 1'b1, 1'b0};
				n = n + 1'b1;
			end
		end

		if (!consumed) begin
			phase_d = PH_PLAIN;
			// Designator code point, when the byte is one.
			if (in_byte >= sft_pkg::LOW_FIRST && in_byte <= sft_pkg::LOW_LAST) begin
				off = in_byte - sft_pkg::LOW_FIRST;
				cp  = sft_pkg::LOW_MAP[off[4:0]];
			end else if (in_byte >= sft_pkg::HIGH_FIRST && in_byte <= sft_pkg::HIGH_LAST) begin
				off = in_byte - sft_pkg::HIGH_FIRST;
				cp  = sft_pkg::HIGH_MAP[off[5:0]];
			end
			acc = sft_pkg::accent_lookup(in_byte[3:0]);

			unique case (phase_q)
				PH_ACCENT: begin
					res[n[sft_pkg::RES_IDX_W-1:0]] = '{in_byte, 1'b1, 1'b0, 1'b0};
					n = n + 1'b1;
					if (known_q) begin
						res[n[sft_pkg::RES_IDX_W-1:0]] = '{8'hCC, 1'b1, 1'b0, 1'b0};
						n = n + 1'b1;
						res[n[sft_pkg::RES_IDX_W-1:0]] = '{{2'b10, accent_q}, 1'b1, 1'b0, 1'b0};
						n = n + 1'b1;
					end
					accent_d = '0;
					known_d  = 1'b0;
				end
				PH_DESIG: begin
					if (in_byte < sft_pkg::LOW_FIRST || in_byte > sft_pkg::HIGH_LAST) begin
						// Out-of-range designator: handled as a plain byte.
						if (in_byte == sft_pkg::BYTE_SEMI) begin
							semi_d = 1'b1;
						end else if (in_byte == sft_pkg::BYTE_ESC) begin
							phase_d = PH_ESC;
						end else begin
							res[n[sft_pkg::RES_IDX_W-1:0]] = '{in_byte, 1'b1, 1'b0, 1'b0};
							n = n + 1'b1;
						end
					end else if (in_byte >= sft_pkg::ACCENT_FIRST &&
							in_byte < sft_pkg::HIGH_FIRST) begin
						known_d  = acc[6];
						accent_d = acc[6] ? acc[5:0] : 6'd0;
						phase_d  = PH_ACCENT;
					end else if (cp < 9'h080) begin
						res[n[sft_pkg::RES_IDX_W-1:0]] = '{cp[7:0], 1'b1, 1'b0, 1'b0};
						n = n + 1'b1;
					end else begin
						res[n[sft_pkg::RES_IDX_W-1:0]] = '{{5'b11000, cp[8:6]}, 1'b1, 1'b0, 1'b0};
						n = n + 1'b1;
						res[n[sft_pkg::RES_IDX_W-1:0]] = '{{2'b10, cp[5:0]}, 1'b1, 1'b0, 1'b0};
						n = n + 1'b1;
					end
				end
				PH_ESC, PH_PLAIN: begin
					if (phase_q == PH_ESC && in_byte == sft_pkg::BYTE_N) begin
						phase_d = PH_DESIG;
					end else if (in_byte == sft_pkg::BYTE_SEMI) begin
						semi_d = 1'b1;
					end else if (in_byte == sft_pkg::BYTE_ESC) begin
						phase_d = PH_ESC;
					end else begin
						res[n[sft_pkg::RES_IDX_W-1:0]] = '{in_byte, 1'b1, 1'b0, 1'b0};
						n = n + 1'b1;
					end
				end
				default: begin
					phase_d = PH_PLAIN;
				end
			endcase
		end

		// Line end closes the field and drops any partial escape.
		if (line_end) begin
			if (semi_d) begin
				semi_d = 1'b0;
				res[n[sft_pkg::RES_IDX_W-1:0]] = '{8'h00, 1'b0, 1'b1, 1'b0};
				n = n + 1'b1;
			end else if (n != '0 && res[n[sft_pkg::RES_IDX_W-1:0] - 1'b1].byte_valid) begin
				res[n[sft_pkg::RES_IDX_W-1:0] - 1'b1].field_end = 1'b1;
			end else begin
				res[n[sft_pkg::RES_IDX_W-1:0]] = '{8'h00, 1'b0, 1'b1, 1'b0};
				n = n + 1'b1;
			end
			res[n[sft_pkg::RES_IDX_W-1:0] - 1'b1].line_done = 1'b1;
			phase_d  = PH_PLAIN;
			accent_d = '0;
			known_d  = 1'b0;
		end
	end

	assign push_bundle.item = res;
	assign push_bundle.cnt  = n;

	// Tokenizer state advances on each input transfer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_PLAIN;
			semi_q   <= 1'b0;
			accent_q <= '0;
			known_q  <= 1'b0;
		end else if (take) begin
			phase_q  <= phase_d;
			semi_q   <= semi_d;
			accent_q <= accent_d;
			known_q  <= known_d;
		end
	end

endmodule

// ===== design/sft_queue.sv =====
// ----------------------------------------------------------------------------
// sft_queue: bundle queue between classifier and serializer
// A short circular queue of result bundles, so that either side can stall
// without holding up the other.
// ----------------------------------------------------------------------------
module sft_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  sft_pkg::bundle_t push_bundle,
	output logic             full,
	input  logic             pop,
	output logic             not_empty,
	output sft_pkg::bundle_t head
);

	sft_pkg::bundle_t entry_q [sft_pkg::QUEUE_DEPTH];
	logic [sft_pkg::Q_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [sft_pkg::Q_CNT_W-1:0] count_q;

	assign full      = (count_q == sft_pkg::Q_CNT_W'(sft_pkg::QUEUE_DEPTH));
	assign not_empty = (count_q != '0);
	assign head      = entry_q[rd_ptr_q];

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_bundle;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ===== design/sft_back.sv =====
// ----------------------------------------------------------------------------
// sft_back: result serializer of the field tokenizer
// Sends the results of the head bundle one per output transfer and pops
// the bundle after its last result.
// ----------------------------------------------------------------------------
module sft_back (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             not_empty,
	input  sft_pkg::bundle_t head,
	output logic             pop,
	output logic             out_valid,
	input  logic             out_stall,
	output logic [7:0]       out_byte,
	output logic             byte_valid,
	output logic             field_end,
	output logic             line_done
);

	logic [sft_pkg::RES_IDX_W-1:0] idx_q;
	logic                          last;
	logic                          xfer;
	sft_pkg::res_t                 cur;

	assign cur        = head.item[idx_q];
	assign out_valid  = not_empty;
	assign out_byte   = cur.data;
	assign byte_valid = cur.byte_valid;
	assign field_end  = cur.field_end;
	assign line_done  = cur.line_done;

	assign xfer = not_empty && !out_stall;
	assign last = ({1'b0, idx_q} + 1'b1) == head.cnt;
	assign pop  = xfer && last;

	// Position within the head bundle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
		end else if (xfer) begin
			idx_q <= last ? '0 : idx_q + 1'b1;
		end
	end

endmodule

// ===== design/sylk_field_tokenizer_unit.sv =====
// Results pass through the registered bundle queue on their way out.
// Throughput: one byte per cycle in unless the queue is full; one result per
// cycle out unless out_stall is set; a byte with k results takes k transfers.
// A four-bundle queue between classifier and serializer absorbs bursts.
// Reset: arst_n clears tokenizer state and empties the queue at once.
// ----------------------------------------------------------------------------
// sylk_field_tokenizer_unit: record-line field tokenizer with ESC N decoding
// Splits record-line bytes into semicolon-separated fields and decodes
// escape sequences to UTF-8.
// ----------------------------------------------------------------------------
module sylk_field_tokenizer_unit (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] in_byte,
	input  logic       line_end,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] out_byte,
	output logic       byte_valid,
	output logic       field_end,
	output logic       line_done
);

	logic             push, pop, q_full, q_not_empty;
	sft_pkg::bundle_t push_bundle, head;

	// Classifier.
	sft_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.in_byte     (in_byte),
		.line_end    (line_end),
		.q_full      (q_full),
		.push        (push),
		.push_bundle (push_bundle)
	);

	// Bundle queue.
	sft_queue u_queue (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.push_bundle (push_bundle),
		.full        (q_full),
		.pop         (pop),
		.not_empty   (q_not_empty),
		.head        (head)
	);

	// Serializer.
	sft_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.not_empty  (q_not_empty),
		.head       (head),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_byte   (out_byte),
		.byte_valid (byte_valid),
		.field_end  (field_end),
		.line_done  (line_done)
	);

endmodule

// ===== tb/sylk_field_tokenizer_unit_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sylk_field_tokenizer_unit_tb: self-checking bench of the field tokenizer
// A directed record set covers literal and ending semicolons and each kind of
// escape. Random well-formed lines with some noise follow, under three idle
// patterns and one long output hold-off. A scoreboard decodes every accepted
// byte on its own and compares each output transfer field by field.
// ----------------------------------------------------------------------------
module sylk_field_tokenizer_unit_tb;

	localparam int CYCLE_LIMIT = 60000;
	localparam int HOLD_CYCLES = 150;
	localparam logic [7:0] NO_ACCENT = 8'hFF;

	// Code points reached through ESC N with a designator of 0x21-0x3F.
	localparam logic [10:0] LOW_CODES [0:30] = '{
		11'h0A1, 11'h0A2, 11'h0A3, 11'h024, 11'h0A5, 11'h023, 11'h0A7, 11'h0A4,
		11'h027, 11'h022, 11'h0AB, 11'h02C, 11'h02D, 11'h02E, 11'h02F, 11'h0B0,
		11'h0B1, 11'h0B2, 11'h0B3, 11'h034, 11'h0B5, 11'h0B6, 11'h0B7, 11'h038,
		11'h027, 11'h022, 11'h0BB, 11'h0BC, 11'h0BD, 11'h0BE, 11'h0BF
	};

	// Code points reached through ESC N with a designator of 0x50-0x7E.
	localparam logic [10:0] HIGH_CODES [0:46] = '{
		11'h0AF, 11'h0AC, 11'h0AE, 11'h0A9, 11'h054, 11'h055, 11'h056, 11'h057,
		11'h058, 11'h059, 11'h05A, 11'h05B, 11'h05C, 11'h05D, 11'h05E, 11'h05F,
		11'h060, 11'h0C6, 11'h0D0, 11'h0AA, 11'h064, 11'h065, 11'h066, 11'h067,
		11'h068, 11'h0D8, 11'h152, 11'h0B0, 11'h0DE, 11'h06D, 11'h06E, 11'h06F,
		11'h070, 11'h0E6, 11'h072, 11'h0F0, 11'h074, 11'h075, 11'h076, 11'h077,
		11'h078, 11'h0F8, 11'h153, 11'h0DF, 11'h0DE, 11'h07D, 11'h07E
	};

	// Combining accent offsets for designators 0x40-0x4F.
	localparam logic [7:0] ACCENT_CODES [0:15] = '{
		NO_ACCENT, 8'h00, 8'h01, 8'h02, 8'h03, NO_ACCENT, NO_ACCENT, NO_ACCENT,
		8'h08, NO_ACCENT, 8'h0A, 8'h27, NO_ACCENT, NO_ACCENT, NO_ACCENT, NO_ACCENT
	};

	typedef enum logic [1:0] {
		PH_TEXT,
		PH_ESC,
		PH_DESIG,
		PH_BASE
	} esc_phase_e;

	// Decodes accepted bytes into the transfers the block must send out and
	// matches every output transfer against the oldest of them.
	class field_scoreboard;
		sft_pkg::res_t decoded_q[$];
		sft_pkg::res_t line_out[$];
		esc_phase_e    phase;
		bit            semi_seen;
		bit [5:0]      accent;
		bit            accent_ok;
		int            errors;
		int            bytes_in;
		int            lines_in;
		int            results_seen;

		function void put(logic [7:0] b, bit v, bit fe);
			sft_pkg::res_t r;
			r.data       = b;
			r.byte_valid = v;
			r.field_end  = fe;
			r.line_done  = 1'b0;
			line_out.push_back(r);
		endfunction

		// Code points below 0x80 go out as one byte, the rest as two.
		function void put_code(logic [10:0] cp);
			if (cp < 11'h080) begin
				put(cp[7:0], 1'b1, 1'b0);
			end else begin
				put({3'b110, cp[10:6]}, 1'b1, 1'b0);
				put({2'b10, cp[5:0]}, 1'b1, 1'b0);
			end
		endfunction

		function void plain(logic [7:0] b);
			if (b == sft_pkg::BYTE_SEMI)
				semi_seen = 1'b1;
			else if (b == sft_pkg::BYTE_ESC)
				phase = PH_ESC;
			else
				put(b, 1'b1, 1'b0);
		endfunction

		// Notes one accepted byte and queues the transfers it causes.
		function void take_byte(logic [7:0] b, logic le);
			bit            done;
			esc_phase_e    ph;
			logic [7:0]    a;
			logic [7:0]    off;
			sft_pkg::res_t r;
			line_out.delete();
			done = 1'b0;
			bytes_in++;
			if (semi_seen) begin
				semi_seen = 1'b0;
				if (b == sft_pkg::BYTE_SEMI) begin
					put(sft_pkg::BYTE_SEMI, 1'b1, 1'b0);
					done = 1'b1;
				end else begin
					put(8'h00, 1'b0, 1'b1);
				end
			end
			if (!done) begin
				ph    = phase;
				phase = PH_TEXT;
				case (ph)
					PH_TEXT: begin
						plain(b);
					end
					PH_ESC: begin
						if (b == sft_pkg::BYTE_N)
							phase = PH_DESIG;
						else
							plain(b);
					end
					PH_DESIG: begin
						if (b < sft_pkg::LOW_FIRST || b > sft_pkg::HIGH_LAST) begin
							plain(b);
						end else if (b <= sft_pkg::LOW_LAST) begin
							off = b - sft_pkg::LOW_FIRST;
							put_code(LOW_CODES[off[4:0]]);
						end else if (b >= sft_pkg::HIGH_FIRST) begin
							off = b - sft_pkg::HIGH_FIRST;
							put_code(HIGH_CODES[off[5:0]]);
						end else begin
							a         = ACCENT_CODES[b[3:0]];
							accent_ok = (a != NO_ACCENT);
							accent    = accent_ok ? a[5:0] : 6'h00;
							phase     = PH_BASE;
						end
					end
					PH_BASE: begin
						put(b, 1'b1, 1'b0);
						if (accent_ok)
							put_code(11'h300 + accent);
						accent    = 6'h00;
						accent_ok = 1'b0;
					end
				endcase
			end
			// The line end closes the field and drops any partial escape.
			if (le) begin
				lines_in++;
				if (semi_seen) begin
					semi_seen = 1'b0;
					put(8'h00, 1'b0, 1'b1);
				end else if (line_out.size() > 0 && line_out[line_out.size() - 1].byte_valid) begin
					r = line_out.pop_back();
					r.field_end = 1'b1;
					line_out.push_back(r);
				end else begin
					put(8'h00, 1'b0, 1'b1);
				end
				r = line_out.pop_back();
				r.line_done = 1'b1;
				line_out.push_back(r);
				phase     = PH_TEXT;
				accent    = 6'h00;
				accent_ok = 1'b0;
			end
			foreach (line_out[i])
				decoded_q.push_back(line_out[i]);
		endfunction

		function void check_result(sft_pkg::res_t got);
			sft_pkg::res_t want;
			results_seen++;
			if (decoded_q.size() == 0) begin
				$error("unexpected output transfer: out_byte %h", got.data);
				errors++;
				return;
			end
			want = decoded_q.pop_front();
			if (got.data !== want.data) begin
				$error("out_byte: expected %h, got %h", want.data, got.data);
				errors++;
			end
			if (got.byte_valid !== want.byte_valid) begin
				$error("byte_valid: expected %b, got %b", want.byte_valid, got.byte_valid);
				errors++;
			end
			if (got.field_end !== want.field_end) begin
				$error("field_end: expected %b, got %b", want.field_end, got.field_end);
				errors++;
			end
			if (got.line_done !== want.line_done) begin
				$error("line_done: expected %b, got %b", want.line_done, got.line_done);
				errors++;
			end
		endfunction

		function int pending();
			return decoded_q.size();
		endfunction
	endclass

	logic       clk = 1'b0;
	logic       arst_n;
	logic       in_valid;
	logic       in_stall;
	logic [7:0] in_byte;
	logic       line_end;
	logic       out_valid;
	logic       out_stall = 1'b0;
	logic [7:0] out_byte;
	logic       byte_valid;
	logic       field_end;
	logic       line_done;

	field_scoreboard sb;
	int send_idle_pct;
	int recv_idle_pct;
	int hold_requests;
	int hold_served;
	int hold_left;
	int cycles;

	sylk_field_tokenizer_unit dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.in_byte    (in_byte),
		.line_end   (line_end),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_byte   (out_byte),
		.byte_valid (byte_valid),
		.field_end  (field_end),
		.line_done  (line_done)
	);

	// Clock with a 10 ns period.
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Run limit in case the block hangs.
	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles", cycles);
			$display("Some tests failed");
			$finish;
		end
	end

	// Output side: check each transfer, then pick the stall for the next cycle.
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			sb.check_result('{data: out_byte, byte_valid: byte_valid,
				field_end: field_end, line_done: line_done});
		if (hold_served != hold_requests) begin
			hold_served = hold_requests;
			hold_left   = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(99) < recv_idle_pct);
		end
	end

	// Offers one byte, waits for its transfer, then maybe idles a while.
	task automatic send_byte(input logic [7:0] b, input logic le);
		in_valid <= 1'b1;
		in_byte  <= b;
		line_end <= le;
		do
			@(posedge clk);
		while (in_stall);
		sb.take_byte(b, le);
		if ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			do
				@(posedge clk);
			while ($urandom_range(99) < send_idle_pct);
		end
	endtask

	function automatic logic [7:0] text_byte();
		logic [7:0] b;
		do
			b = 8'($urandom_range(255));
		while (b == sft_pkg::BYTE_SEMI || b == sft_pkg::BYTE_ESC);
		return b;
	endfunction

	// Builds one line from random tokens, mostly well formed, and sends it.
	task automatic send_line(input int tokens);
		logic [7:0] line_q[$];
		logic [7:0] d;
		int         kind;
		repeat (tokens) begin
			kind = $urandom_range(99);
			if (kind < 38) begin
				line_q.push_back(text_byte());
			end else if (kind < 48) begin
				line_q.push_back(sft_pkg::BYTE_SEMI);
			end else if (kind < 56) begin
				line_q.push_back(sft_pkg::BYTE_SEMI);
				line_q.push_back(sft_pkg::BYTE_SEMI);
			end else if (kind < 71) begin
				line_q.push_back(sft_pkg::BYTE_ESC);
				line_q.push_back(sft_pkg::BYTE_N);
				if ($urandom_range(1))
					d = 8'($urandom_range(sft_pkg::LOW_FIRST, sft_pkg::LOW_LAST));
				else
					d = 8'($urandom_range(sft_pkg::HIGH_FIRST, sft_pkg::HIGH_LAST));
				line_q.push_back(d);
			end else if (kind < 81) begin
				line_q.push_back(sft_pkg::BYTE_ESC);
				line_q.push_back(sft_pkg::BYTE_N);
				line_q.push_back(8'($urandom_range(sft_pkg::ACCENT_FIRST,
					sft_pkg::HIGH_FIRST - 1)));
				line_q.push_back(8'($urandom_range(255)));
			end else if (kind < 86) begin
				do
					d = 8'($urandom_range(255));
				while (d == sft_pkg::BYTE_N);
				line_q.push_back(sft_pkg::BYTE_ESC);
				line_q.push_back(d);
			end else if (kind < 91) begin
				if ($urandom_range(1))
					d = 8'($urandom_range(0, sft_pkg::LOW_FIRST - 1));
				else
					d = 8'($urandom_range(sft_pkg::HIGH_LAST + 1, 255));
				line_q.push_back(sft_pkg::BYTE_ESC);
				line_q.push_back(sft_pkg::BYTE_N);
				line_q.push_back(d);
			end else begin
				line_q.push_back(8'($urandom_range(255)));
			end
		end
		// Now and then the line stops in the middle of an escape.
		kind = $urandom_range(99);
		if (kind < 5) begin
			line_q.push_back(sft_pkg::BYTE_ESC);
		end else if (kind < 10) begin
			line_q.push_back(sft_pkg::BYTE_ESC);
			line_q.push_back(sft_pkg::BYTE_N);
		end else if (kind < 14) begin
			line_q.push_back(sft_pkg::BYTE_ESC);
			line_q.push_back(sft_pkg::BYTE_N);
			line_q.push_back(8'($urandom_range(sft_pkg::ACCENT_FIRST,
				sft_pkg::HIGH_FIRST - 1)));
		end
		foreach (line_q[i])
			send_byte(line_q[i], i == line_q.size() - 1);
	endtask

	task automatic run_lines(input int sidle, input int ridle, input int nbytes);
		int start;
		send_idle_pct = sidle;
		recv_idle_pct = ridle;
		start = sb.bytes_in;
		while (sb.bytes_in - start < nbytes)
			send_line($urandom_range(1, 8));
	endtask

	// Reset, directed records, then three random phases.
	initial begin
		sb            = new();
		arst_n        = 1'b0;
		in_valid      = 1'b0;
		in_byte       = 8'h00;
		line_end      = 1'b0;
		send_idle_pct = 29;
		recv_idle_pct = 57;
		hold_requests = 0;
		hold_served   = 0;
		hold_left     = 0;
		cycles        = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Literal semicolon, field ends, and the lowest byte ending a line.
		send_byte(8'h41, 1'b0);
		send_byte(sft_pkg::BYTE_SEMI, 1'b0);
		send_byte(sft_pkg::BYTE_SEMI, 1'b0);
		send_byte(8'h42, 1'b0);
		send_byte(sft_pkg::BYTE_SEMI, 1'b0);
		send_byte(8'h00, 1'b1);
		// Dropped ESC, a table lookup, out-of-range designator and accents.
		send_byte(sft_pkg::BYTE_ESC, 1'b0);
		send_byte(8'h78, 1'b0);
		send_byte(sft_pkg::BYTE_ESC, 1'b0);
		send_byte(sft_pkg::BYTE_N, 1'b0);
		send_byte(sft_pkg::LOW_FIRST, 1'b0);
		send_byte(sft_pkg::BYTE_ESC, 1'b0);
		send_byte(sft_pkg::BYTE_N, 1'b0);
		send_byte(sft_pkg::HIGH_LAST + 8'h01, 1'b0);
		send_byte(sft_pkg::BYTE_ESC, 1'b0);
		send_byte(sft_pkg::BYTE_N, 1'b0);
		send_byte(sft_pkg::ACCENT_FIRST + 8'h0B, 1'b0);
		send_byte(sft_pkg::BYTE_SEMI, 1'b0);
		send_byte(sft_pkg::BYTE_ESC, 1'b0);
		send_byte(sft_pkg::BYTE_N, 1'b0);
		send_byte(sft_pkg::ACCENT_FIRST, 1'b0);
		send_byte(8'hFF, 1'b0);
		// Trailing semicolon ends the line without an empty field.
		send_byte(sft_pkg::BYTE_SEMI, 1'b1);
		// Escape cut off by the line end.
		send_byte(sft_pkg::BYTE_ESC, 1'b0);
		send_byte(sft_pkg::BYTE_N, 1'b1);

		run_lines(29, 57, 65);
		run_lines(57, 29, 65);
		// Long output hold-off with a busy sender fills the block.
		hold_requests++;
		run_lines(0, 0, 65);
		in_valid <= 1'b0;

		while (sb.pending() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);

		$display("Sent %0d bytes in %0d lines and checked %0d output transfers,",
			sb.bytes_in, sb.lines_in, sb.results_seen);
		$display("covering escapes, accents, semicolons, stalls and a long hold-off.");
		if (sb.errors == 0 && sb.pending() == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule
